[hw/rtl/c2p_pkg.sv]
package c2p_pkg;

  // Sizing
  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_CELLS     = (CORDIC_STAGES > COORD_WIDTH) ? CORDIC_STAGES : COORD_WIDTH;
  localparam int IDX_W         = $clog2(NUM_CELLS);
  localparam int SQ_W          = 2 * COORD_WIDTH;
  localparam int PRE_SHIFT     = 46 - COORD_WIDTH;
  localparam int CORD_W        = 48;
  localparam int Z_W           = 27;
  localparam int T_W           = 27;
  localparam int ROUND_SHIFT   = 11;
  localparam int ANG_W         = T_W - ROUND_SHIFT;
  localparam int RAD_W         = 16;
  localparam int RAD_FULL_W    = COORD_WIDTH + 1;
  localparam int RAD_CMP_W     = (RAD_FULL_W > RAD_W) ? RAD_FULL_W : RAD_W;
  localparam int ATAN_IDX_W    = 5;

  // Angles, 24 fraction bits
  localparam logic [T_W-1:0]        ANG_PI            = T_W'(52707179);
  localparam logic [T_W-1:0]        ANG_HALF_PI       = T_W'(26353589);
  localparam logic [T_W-1:0]        ANG_THREE_HALF_PI = T_W'(79060768);
  localparam logic [T_W-1:0]        ANG_TWO_PI        = T_W'(105414357);
  localparam logic signed [Z_W-1:0] ANG_HALF_PI_Z     = Z_W'(26353589);
  localparam logic [T_W-1:0]        ANG_ROUND         = T_W'(1024);
  // 2*pi in Q3.13
  localparam logic [ANG_W-1:0]      ANG_TWO_PI_Q13    = ANG_W'(51472);
  localparam logic [RAD_W-1:0]      RAD_MAX           = '1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [ANG_W-1:0] angle;
  } out_item_t;

  // Quadrant flags carried alongside the datapath
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
  } quad_t;

  typedef struct packed {
    quad_t                    quad;
    logic signed [CORD_W-1:0] cx;
    logic signed [CORD_W-1:0] cy;
    logic signed [Z_W-1:0]    cz;
    logic [SQ_W-1:0]          rem;
    logic [SQ_W-1:0]          root;
  } cell_data_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    unique case (idx)
      5'd0:    val = Z_W'(13176795);
      5'd1:    val = Z_W'(7778716);
      5'd2:    val = Z_W'(4110060);
      5'd3:    val = Z_W'(2086331);
      5'd4:    val = Z_W'(1047214);
      5'd5:    val = Z_W'(524117);
      5'd6:    val = Z_W'(262123);
      5'd7:    val = Z_W'(131069);
      5'd8:    val = Z_W'(65536);
      5'd9:    val = Z_W'(32768);
      5'd10:   val = Z_W'(16384);
      5'd11:   val = Z_W'(8192);
      5'd12:   val = Z_W'(4096);
      5'd13:   val = Z_W'(2048);
      5'd14:   val = Z_W'(1024);
      5'd15:   val = Z_W'(512);
      5'd16:   val = Z_W'(256);
      5'd17:   val = Z_W'(128);
      5'd18:   val = Z_W'(64);
      5'd19:   val = Z_W'(32);
      5'd20:   val = Z_W'(16);
      5'd21:   val = Z_W'(8);
      5'd22:   val = Z_W'(4);
      5'd23:   val = Z_W'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/c2p_front.sv]
module c2p_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  input  c2p_pkg::in_item_t     up_item,
  output logic                  up_ready,
  output logic                  dn_valid,
  output c2p_pkg::cell_data_t   dn_data,
  input  logic                  dn_ready
);
  import c2p_pkg::*;

  logic                   abs_valid_r;
  logic [COORD_WIDTH-1:0] ax_r, ax_nxt;
  logic [COORD_WIDTH-1:0] ay_r, ay_nxt;
  quad_t                  quad_r, quad_nxt;
  logic                   abs_ready;
  logic [COORD_WIDTH-1:0] x_raw, y_raw;

  logic                   sq_valid_r;
  cell_data_t             sq_data_r, sq_data_nxt;
  logic                   sq_ready;

  // Stage 1: magnitudes and quadrant flags
  always_comb begin
    x_raw = up_item.x_coord;
    y_raw = up_item.y_coord;
    quad_nxt.x_zero = (x_raw == '0);
    quad_nxt.y_zero = (y_raw == '0);
    quad_nxt.x_neg  = x_raw[COORD_WIDTH-1];
    quad_nxt.y_neg  = y_raw[COORD_WIDTH-1];
    ax_nxt = x_raw[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - x_raw) : x_raw;
    ay_nxt = y_raw[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - y_raw) : y_raw;
  end

  assign abs_ready = !abs_valid_r || sq_ready;
  assign up_ready  = abs_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_valid_r <= 1'b0;
    end else if (abs_ready) begin
      abs_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (abs_ready && up_valid) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      quad_r <= quad_nxt;
    end
  end

  // Stage 2: sum of squares and CORDIC prescale
  always_comb begin
    sq_data_nxt.quad = quad_r;
    sq_data_nxt.cx   = signed'(CORD_W'(ax_r) << PRE_SHIFT);
    sq_data_nxt.cy   = signed'(CORD_W'(ay_r) << PRE_SHIFT);
    sq_data_nxt.cz   = '0;
    sq_data_nxt.rem  = SQ_W'(ax_r) * SQ_W'(ax_r) + SQ_W'(ay_r) * SQ_W'(ay_r);
    sq_data_nxt.root = '0;
  end

  assign sq_ready = !sq_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (sq_ready) begin
      sq_valid_r <= abs_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready && abs_valid_r) begin
      sq_data_r <= sq_data_nxt;
    end
  end

  assign dn_valid = sq_valid_r;
  assign dn_data  = sq_data_r;

endmodule

[hw/rtl/c2p_cell.sv]
module c2p_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [c2p_pkg::IDX_W-1:0] cell_idx,
  input  logic                      up_valid,
  input  c2p_pkg::cell_data_t       up_data,
  output logic                      up_ready,
  output logic                      dn_valid,
  output c2p_pkg::cell_data_t       dn_data,
  input  logic                      dn_ready
);
  import c2p_pkg::*;

  logic                     valid_r;
  cell_data_t               data_r, data_nxt;
  logic                     cordic_en, sqrt_en;
  logic signed [CORD_W-1:0] cx, cy, xs, ys;
  logic signed [Z_W-1:0]    atan_val;
  logic [SQ_W-1:0]          sq_one, trial;

  // One CORDIC vectoring step and one square-root digit
  always_comb begin
    cordic_en = (int'(cell_idx) < CORDIC_STAGES);
    sqrt_en   = (int'(cell_idx) < COORD_WIDTH);
    cx        = up_data.cx;
    cy        = up_data.cy;
    xs        = cx >>> cell_idx;
    ys        = cy >>> cell_idx;
    atan_val  = atan_lut(ATAN_IDX_W'(cell_idx));
    sq_one    = sqrt_en ? (SQ_W'(1) << (2 * (COORD_WIDTH - 1 - int'(cell_idx)))) : '0;
    trial     = up_data.root + sq_one;

    data_nxt = up_data;
    if (cordic_en) begin
      if (!cy[CORD_W-1]) begin
        data_nxt.cx = cx + ys;
        data_nxt.cy = cy - xs;
        data_nxt.cz = up_data.cz + atan_val;
      end else begin
        data_nxt.cx = cx - ys;
        data_nxt.cy = cy + xs;
        data_nxt.cz = up_data.cz - atan_val;
      end
    end
    if (sqrt_en) begin
      if (up_data.rem >= trial) begin
        data_nxt.rem  = up_data.rem - trial;
        data_nxt.root = (up_data.root >> 1) + sq_one;
      end else begin
        data_nxt.root = up_data.root >> 1;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[hw/rtl/c2p_finish.sv]
module c2p_finish (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  input  c2p_pkg::cell_data_t   up_data,
  output logic                  up_ready,
  output logic                  dn_valid,
  output c2p_pkg::out_item_t    dn_item,
  input  logic                  dn_ready
);
  import c2p_pkg::*;

  logic                  quad_valid_r;
  logic [T_W-1:0]        t_r, t_nxt;
  logic [RAD_FULL_W-1:0] rad_r, rad_nxt;
  logic                  quad_ready;
  logic signed [Z_W-1:0] z;
  logic [T_W-1:0]        phi;

  logic                  out_valid_r;
  out_item_t             out_r, out_nxt;
  logic                  out_ready;
  logic [T_W-1:0]        t_rnd;
  logic [ANG_W-1:0]      ang_q13;

  // Stage A: clamp, quadrant correction, radius rounding
  always_comb begin
    z = up_data.cz;
    if (z < 0) begin
      phi = '0;
    end else if (z > ANG_HALF_PI_Z) begin
      phi = ANG_HALF_PI;
    end else begin
      phi = T_W'($unsigned(z));
    end
    // a point on the x axis has an exact zero phi
    if (up_data.quad.y_zero) begin
      phi = '0;
    end

    if (up_data.quad.x_zero) begin
      if (up_data.quad.y_zero) begin
        t_nxt = '0;
      end else if (up_data.quad.y_neg) begin
        t_nxt = ANG_THREE_HALF_PI;
      end else begin
        t_nxt = ANG_HALF_PI;
      end
    end else if (up_data.quad.x_neg) begin
      t_nxt = up_data.quad.y_neg ? (ANG_PI + phi) : (ANG_PI - phi);
    end else begin
      t_nxt = up_data.quad.y_neg ? (ANG_TWO_PI - phi) : phi;
    end

    rad_nxt = {1'b0, up_data.root[COORD_WIDTH-1:0]}
            + RAD_FULL_W'(up_data.rem > up_data.root);
  end

  assign quad_ready = !quad_valid_r || out_ready;
  assign up_ready   = quad_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_valid_r <= 1'b0;
    end else if (quad_ready) begin
      quad_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_ready && up_valid) begin
      t_r   <= t_nxt;
      rad_r <= rad_nxt;
    end
  end

  // Stage B: round to Q3.13, wrap at two pi, saturate radius
  always_comb begin
    t_rnd   = t_r + ANG_ROUND;
    ang_q13 = t_rnd[T_W-1:ROUND_SHIFT];
    if (ang_q13 >= ANG_TWO_PI_Q13) begin
      out_nxt.angle = ang_q13 - ANG_TWO_PI_Q13;
    end else begin
      out_nxt.angle = ang_q13;
    end
    if (RAD_CMP_W'(rad_r) > RAD_CMP_W'(RAD_MAX)) begin
      out_nxt.radius = RAD_MAX;
    end else begin
      out_nxt.radius = RAD_W'(rad_r);
    end
  end

  assign out_ready = !out_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= quad_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && quad_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_item  = out_r;

endmodule

[hw/rtl/cartesian_to_polar_unit.sv]
// Cartesian to polar converter.
// Input channel: in_valid / in_stall / in_item carries one point (x_coord, y_coord),
// signed two's complement in any common fixed-point scale.
// Result channel: out_valid / out_stall / out_item carries the rounded Euclidean radius
// in the input scale and the angle in unsigned Q3.13 radians, 0 up to below 2*pi.
// The pipeline has two entry stages for magnitudes and the sum of squares, one cell per
// CORDIC step and square-root digit, and two exit stages for quadrant correction and
// rounding.
// Throughput is one item per clock unless out_stall holds the pipeline.
// Every stage holds its own valid bit, so a stalled result sits in the output register
// while the stages behind it keep filling; in_stall rises only once all stages are full.
// A stalled result holds its value until taken.
// Reset (rst_n low, synchronous) empties every stage; no item is lost or created
// apart from those in flight, which are dropped.
module cartesian_to_polar_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  c2p_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output c2p_pkg::out_item_t out_item
);
  import c2p_pkg::*;

  logic       chain_valid [NUM_CELLS+1];
  cell_data_t chain_data  [NUM_CELLS+1];
  logic       chain_ready [NUM_CELLS+1];
  logic       front_ready;
  logic       out_ready;

  assign in_stall  = !front_ready;
  assign out_ready = !out_stall;

  // Entry stages
  c2p_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_item  (in_item),
    .up_ready (front_ready),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_ready (chain_ready[0])
  );

  // Row of CORDIC / square-root cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    c2p_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .up_valid (chain_valid[i]),
      .up_data  (chain_data[i]),
      .up_ready (chain_ready[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_data  (chain_data[i+1]),
      .dn_ready (chain_ready[i+1])
    );
  end

  // Exit stages
  c2p_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[NUM_CELLS]),
    .up_data  (chain_data[NUM_CELLS]),
    .up_ready (chain_ready[NUM_CELLS]),
    .dn_valid (out_valid),
    .dn_item  (out_item),
    .dn_ready (out_ready)
  );

endmodule

[hw/rtl/c2p_checker.sv]
module c2p_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input c2p_pkg::out_item_t out_item
);
  import c2p_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result dropped or changed");

  // Input is held off only while the result side is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_stall)
    else $error("input stalled with result side free");

  // Angle wrapped below two pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.angle < ANG_TWO_PI_Q13)
    else $error("angle not wrapped");

  // Zero radius only at the origin, whose angle is zero
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.radius == '0) |-> (out_item.angle == '0))
    else $error("origin angle not zero");

endmodule

bind cartesian_to_polar_unit c2p_checker u_checker (.*);
